// File: rtl/cbss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbss_pkg: shared types for the cubic b-spline segment sampler
// Beat layouts of the control point and sample channels, and the width
// and reset value of the interval count register.
// ----------------------------------------------------------------------------
package cbss_pkg;

  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd16;

  // four control points, signed q8.8
  typedef struct packed {
    logic signed [15:0] point0_x;
    logic signed [15:0] point0_y;
    logic signed [15:0] point1_x;
    logic signed [15:0] point1_y;
    logic signed [15:0] point2_x;
    logic signed [15:0] point2_y;
    logic signed [15:0] point3_x;
    logic signed [15:0] point3_y;
  } cbss_in_t;

  // one curve sample
  typedef struct packed {
    logic signed [15:0] curve_x;
    logic signed [15:0] curve_y;
    logic [15:0]        vertex_index;
    logic               has_segment;
    logic               last;
  } cbss_out_t;

endpackage
`default_nettype wire

// File: rtl/cubic_bspline_segment_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bspline_segment_sampler: uniform cubic b-spline segment evaluation
// Takes the four control points of one segment and emits N+1 samples at
// p = i/N, each with a running vertex index, a line-follows flag and a last
// flag. All multiplications run through one shared multiplier.
// ----------------------------------------------------------------------------
// Each input beat is worked on alone: in_ready is high only while the block
// is idle. N is the interval count (16 after reset; 0 reads as 1, values
// above MAX_SAMPLES read as MAX_SAMPLES). The work is paced by the single
// 34x22 multiplier, which for each sample forms p^2 and p^3, sixteen
// partial products of points and basis weights (x and y, each weight in
// two halves) and one divide-by-three reciprocal product per coordinate.
// The step in p comes from a constant table of 65536/N, so no divider is
// needed. A finished sample sits in the output register, so the next
// sample is computed while it waits to be taken.
module cubic_bspline_segment_sampler #(
  parameter int MAX_SAMPLES = 63
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire cbss_pkg::cbss_in_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output cbss_pkg::cbss_out_t               out_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic [cbss_pkg::CFG_W-1:0]   cfg_wr_data
);
  import cbss_pkg::*;

  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int P_W   = 17;   // p in q1.16, reaches 1.0
  localparam int P2_W  = 33;
  localparam int P3_W  = 49;
  localparam int WF_W  = 52;   // weights in q.48, signed working width
  localparam int W_W   = 43;   // weights in q.40
  localparam int WLO_W = 22;
  localparam int MA_W  = 34;
  localparam int MB_W  = 22;
  localparam int PR_W  = 56;
  localparam int ACC_W = 60;
  localparam int RSH   = 41;
  localparam int T_W   = ACC_W - RSH;
  localparam int U_W   = 18;
  localparam int Q_LSB = 20;

  localparam logic [P_W-1:0]          P_ONE     = 17'h10000;
  localparam logic signed [WF_W-1:0]  ONE48     = WF_W'(64'd1 << 48);
  localparam logic signed [ACC_W-1:0] RND_BIAS  = ACC_W'(64'd3 << 40);
  localparam logic signed [T_W-1:0]   T_MAX     = 19'sd98303;
  localparam logic signed [T_W-1:0]   T_MIN     = -19'sd98304;
  localparam logic [MB_W-1:0]         RECIP3    = 22'd349526;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_CU, S_WGT, S_MAC, S_ACC, S_RND, S_DIV, S_CAP, S_EMIT
  } state_t;

  state_t                    state_r;
  logic [CFG_W-1:0]          cfg_spc_r;
  logic [15:0]               idx_r;
  logic                      out_valid_r;
  cbss_out_t                 out_data_r;

  logic signed [15:0]        pts_r [8];
  logic [IDX_W-1:0]          n_r;
  logic [IDX_W-1:0]          i_r;
  logic [IDX_W-1:0]          rem_r;
  logic [IDX_W-1:0]          rs_r;
  logic [P_W-1:0]            qs_r;
  logic [P_W-1:0]            p_r;
  logic [P2_W-1:0]           p2_r;
  logic [W_W-1:0]            w_r [4];
  logic                      c_r;
  logic [2:0]                cnt_r;
  logic signed [PR_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [U_W-1:0]            u_r;
  logic signed [15:0]        cx_r;
  logic signed [15:0]        cy_r;

  // ---- step table: 65536 / n as quotient and remainder
  logic [P_W-1:0]   qs_tab [MAX_SAMPLES+1];
  logic [IDX_W-1:0] rs_tab [MAX_SAMPLES+1];

  assign qs_tab[0] = '0;
  assign rs_tab[0] = '0;
  for (genvar n = 1; n <= MAX_SAMPLES; n++) begin : g_recip
    localparam int QS = 65536 / n;
    localparam int RS = 65536 % n;
    assign qs_tab[n] = P_W'(QS);
    assign rs_tab[n] = IDX_W'(RS);
  end

  logic [IDX_W-1:0] n_eff;
  always_comb begin
    if (cfg_spc_r == '0) begin
      n_eff = IDX_W'(1);
    end else if (int'(cfg_spc_r) > MAX_SAMPLES) begin
      n_eff = IDX_W'(MAX_SAMPLES);
    end else begin
      n_eff = IDX_W'(cfg_spc_r);
    end
  end

  // ---- next p = floor((i+1)*65536/n), kept as quotient and remainder
  logic [IDX_W:0]   rsum;
  logic [IDX_W-1:0] rem_nxt;
  logic [P_W-1:0]   p_nxt;
  assign rsum = {1'b0, rem_r} + {1'b0, rs_r};
  always_comb begin
    if (rsum >= {1'b0, n_r}) begin
      rem_nxt = IDX_W'(rsum - {1'b0, n_r});
      p_nxt   = p_r + qs_r + P_W'(1);
    end else begin
      rem_nxt = rsum[IDX_W-1:0];
      p_nxt   = p_r + qs_r;
    end
  end

  // ---- shared multiplier, signed a by unsigned b, product registered
  logic signed [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]             mul_b;
  logic signed [MA_W+MB_W:0]   mul_full;
  logic [W_W-1:0]              w_sel;
  logic signed [15:0]          coord;

  assign w_sel = w_r[cnt_r[2:1]];
  assign coord = pts_r[{cnt_r[2:1], c_r}];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        mul_a = MA_W'(p_r);
        mul_b = MB_W'(p_r);
      end
      S_CU: begin
        mul_a = MA_W'(prod_r[P2_W-1:0]);
        mul_b = MB_W'(p_r);
      end
      S_MAC: begin
        mul_a = MA_W'(coord);
        mul_b = cnt_r[0] ? MB_W'(w_sel[W_W-1:WLO_W]) : w_sel[WLO_W-1:0];
      end
      S_DIV: begin
        mul_a = MA_W'(u_r);
        mul_b = RECIP3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // ---- basis weights times 6, q.48, from p, p^2 and p^3 (p^3 in prod_r)
  logic signed [WF_W-1:0] p3_s, t2_s, t1_s;
  logic signed [WF_W-1:0] w48 [4];
  logic [W_W-1:0]         w_nxt [4];

  assign p3_s = WF_W'(prod_r[P3_W-1:0]);
  assign t2_s = WF_W'({p2_r, 16'b0});
  assign t1_s = WF_W'({p_r, 32'b0});

  always_comb begin
    w48[0] = ONE48 - p3_s + ((t2_s <<< 1) + t2_s) - ((t1_s <<< 1) + t1_s);
    w48[1] = ((p3_s <<< 1) + p3_s) - ((t2_s <<< 2) + (t2_s <<< 1)) + (ONE48 <<< 2);
    w48[2] = ONE48 - ((p3_s <<< 1) + p3_s) + ((t2_s <<< 1) + t2_s)
           + ((t1_s <<< 1) + t1_s);
    w48[3] = p3_s;
    for (int k = 0; k < 4; k++) begin
      w_nxt[k] = w48[k][W_W+7:8];
    end
  end

  // ---- accumulate: upper weight halves land 22 bits up
  logic                    shift_hi;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_sum;
  assign shift_hi = (state_r == S_ACC) ? 1'b1 : ~cnt_r[0];
  assign prod_ext = shift_hi ? (ACC_W'(prod_r) <<< WLO_W) : ACC_W'(prod_r);
  assign acc_sum  = acc_r + prod_ext;

  // ---- round half up, clamp, offset so the divide by three sees u >= 0
  logic signed [ACC_W-1:0] acc_b;
  logic signed [T_W-1:0]   t_s;
  logic signed [T_W-1:0]   t_c;
  logic signed [T_W-1:0]   t_u;
  logic [U_W-1:0]          u_nxt;
  assign acc_b = acc_r + RND_BIAS;
  assign t_s   = $signed(acc_b[ACC_W-1:RSH]);
  always_comb begin
    if (t_s > T_MAX) begin
      t_c = T_MAX;
    end else if (t_s < T_MIN) begin
      t_c = T_MIN;
    end else begin
      t_c = t_s;
    end
  end
  assign t_u   = t_c - T_MIN;
  assign u_nxt = t_u[U_W-1:0];

  // floor(u/3) comes out offset by 32768: flip the sign bit
  logic [15:0]        q_res;
  logic signed [15:0] coord_res;
  assign q_res     = prod_r[Q_LSB+15:Q_LSB];
  assign coord_res = $signed({~q_res[15], q_res[14:0]});

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_spc_r   <= CFG_RESET;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_spc_r <= cfg_wr_data;
      end
      // in the emit state the output register is handled below
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      prod_r <= mul_full[PR_W-1:0];

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pts_r[0] <= in_data.point0_x;
            pts_r[1] <= in_data.point0_y;
            pts_r[2] <= in_data.point1_x;
            pts_r[3] <= in_data.point1_y;
            pts_r[4] <= in_data.point2_x;
            pts_r[5] <= in_data.point2_y;
            pts_r[6] <= in_data.point3_x;
            pts_r[7] <= in_data.point3_y;
            n_r      <= n_eff;
            qs_r     <= qs_tab[n_eff];
            rs_r     <= rs_tab[n_eff];
            i_r      <= '0;
            p_r      <= '0;
            rem_r    <= '0;
            state_r  <= S_SQ;
          end
        end
        S_SQ: begin
          state_r <= S_CU;
        end
        S_CU: begin
          p2_r    <= prod_r[P2_W-1:0];
          state_r <= S_WGT;
        end
        S_WGT: begin
          for (int k = 0; k < 4; k++) begin
            w_r[k] <= w_nxt[k];
          end
          c_r     <= 1'b0;
          cnt_r   <= '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          // first cycle of a coordinate: nothing of it in prod_r yet
          if (cnt_r == '0) begin
            acc_r <= '0;
          end else begin
            acc_r <= acc_sum;
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          acc_r   <= acc_sum;
          state_r <= S_RND;
        end
        S_RND: begin
          u_r     <= u_nxt;
          state_r <= S_DIV;
        end
        S_DIV: begin
          state_r <= S_CAP;
        end
        S_CAP: begin
          if (!c_r) begin
            cx_r    <= coord_res;
            c_r     <= 1'b1;
            cnt_r   <= '0;
            state_r <= S_MAC;
          end else begin
            cy_r    <= coord_res;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.curve_x      <= cx_r;
            out_data_r.curve_y      <= cy_r;
            out_data_r.vertex_index <= idx_r;
            out_data_r.has_segment  <= (i_r != n_r);
            out_data_r.last         <= (i_r == n_r);
            idx_r                   <= idx_r + 16'd1;
            if (i_r == n_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + IDX_W'(1);
              p_r     <= p_nxt;
              rem_r   <= rem_nxt;
              state_r <= S_SQ;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a segment is in progress");

  a_p_reaches_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) && (i_r == n_r) |-> (p_r == P_ONE))
    else $error("parameter step does not land on 1.0 at the last sample");

  a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (rem_r < n_r) && (i_r <= n_r))
    else $error("step remainder or sample count out of range");

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: cubic b-spline segment sampler
// Sends control point beats at several interval counts and checks every
// curve sample against a bit-accurate fixed-point evaluation of the segment,
// with random gaps on the point side and random stalls on the sample side.
// ----------------------------------------------------------------------------
module testbench;
  import cbss_pkg::*;

  localparam int MAX_INTERVALS = 63;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int TAIL_CYCLES   = 2000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  cbss_in_t            in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  cbss_out_t           out_data;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;

  cbss_out_t           pending_samples[$];
  logic [CFG_W-1:0]    interval_setting = CFG_RESET;
  logic [15:0]         vertex_next = '0;
  logic                steady_flow = 1'b0;
  int                  mismatch_count = 0;
  int                  cycle_count = 0;

  cubic_bspline_segment_sampler uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sample side stalls about 9 percent of the time unless steady_flow is set
  always @(negedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= 9);
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // round to nearest (ties up) of s / (6 * 2^40), then saturate
  function automatic logic [15:0] round_coord(input longint s);
    longint den;
    longint num;
    longint q;
    den = longint'(12) <<< 40;
    num = 2 * s + (longint'(6) <<< 40);
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic predict_segment(input cbss_in_t seg);
    longint    xs[4];
    longint    ys[4];
    longint    w[4];
    longint    p, p2, p3, t1, t2, one, sx, sy;
    int        n;
    cbss_out_t smp;
    n = int'(interval_setting);
    if (n == 0) n = 1;
    if (n > MAX_INTERVALS) n = MAX_INTERVALS;
    xs[0] = seg.point0_x; ys[0] = seg.point0_y;
    xs[1] = seg.point1_x; ys[1] = seg.point1_y;
    xs[2] = seg.point2_x; ys[2] = seg.point2_y;
    xs[3] = seg.point3_x; ys[3] = seg.point3_y;
    one = longint'(1) <<< 48;
    for (int i = 0; i <= n; i++) begin
      p  = (longint'(i) <<< 16) / longint'(n);
      p2 = p * p;
      p3 = p2 * p;
      t2 = p2 <<< 16;
      t1 = p <<< 32;
      // basis weights times six in q.48, floored to q.40
      w[0] = (-p3 + 3 * t2 - 3 * t1 + one) >>> 8;
      w[1] = (3 * p3 - 6 * t2 + 4 * one) >>> 8;
      w[2] = (-3 * p3 + 3 * t2 + 3 * t1 + one) >>> 8;
      w[3] = p3 >>> 8;
      sx = xs[0] * w[0] + xs[1] * w[1] + xs[2] * w[2] + xs[3] * w[3];
      sy = ys[0] * w[0] + ys[1] * w[1] + ys[2] * w[2] + ys[3] * w[3];
      smp.curve_x      = round_coord(sx);
      smp.curve_y      = round_coord(sy);
      smp.vertex_index = vertex_next;
      smp.has_segment  = (i != n);
      smp.last         = (i == n);
      pending_samples.push_back(smp);
      vertex_next = vertex_next + 16'd1;
    end
  endtask

  always @(posedge clk) begin : check_samples
    cbss_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample beat with none pending, index %0d",
                                  out_data.vertex_index));
      end else begin
        want = pending_samples.pop_front();
        if (out_data.curve_x !== want.curve_x)
          report_mismatch($sformatf("vertex %0d curve_x got %0d want %0d",
                                    want.vertex_index, out_data.curve_x, want.curve_x));
        if (out_data.curve_y !== want.curve_y)
          report_mismatch($sformatf("vertex %0d curve_y got %0d want %0d",
                                    want.vertex_index, out_data.curve_y, want.curve_y));
        if (out_data.vertex_index !== want.vertex_index)
          report_mismatch($sformatf("vertex_index got %0d want %0d",
                                    out_data.vertex_index, want.vertex_index));
        if (out_data.has_segment !== want.has_segment)
          report_mismatch($sformatf("vertex %0d has_segment got %b want %b",
                                    want.vertex_index, out_data.has_segment,
                                    want.has_segment));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("vertex %0d last got %b want %b",
                                    want.vertex_index, out_data.last, want.last));
      end
    end
  end

  // called just after a negedge; leaves valid low at a negedge
  task automatic send_segment(input cbss_in_t seg);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 9) @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= seg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_segment(seg);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_samples_drained();
    @(negedge clk);
    while (pending_samples.size() != 0) @(negedge clk);
  endtask

  task automatic write_interval_count(input logic [CFG_W-1:0] count);
    wait_samples_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    interval_setting = count;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic cbss_in_t uniform_segment(input logic [15:0] v);
    return {8{v}};
  endfunction

  function automatic logic [15:0] corner_value();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cbss_in_t random_segment();
    logic [15:0] c[8];
    logic [15:0] base_x;
    logic [15:0] base_y;
    int          style;
    style  = $urandom_range(9);
    base_x = 16'($urandom);
    base_y = 16'($urandom);
    for (int k = 0; k < 8; k++) begin
      case (style)
        0:       c[k] = corner_value();
        // clustered points, like a smooth path
        1, 2:    c[k] = ((k % 2) ? base_y : base_x) + 16'($urandom_range(1023)) - 16'd512;
        default: c[k] = 16'($urandom);
      endcase
    end
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
  endfunction

  task automatic test_reset_interval();
    cbss_in_t seg;
    send_segment(uniform_segment(16'h0000));
    send_segment(uniform_segment(16'h7FFF));
    send_segment(uniform_segment(16'h8000));
    send_segment(uniform_segment(16'h0001));
    send_segment(uniform_segment(16'hFFFF));
    send_segment({4{16'h7FFF, 16'h8000}});
    send_segment({4{16'h8000, 16'h7FFF}});
    // one point at the top, the rest at the bottom
    for (int k = 0; k < 4; k++) begin
      seg = uniform_segment(16'h8000);
      case (k)
        0: begin seg.point0_x = 16'h7FFF; seg.point0_y = 16'h7FFF; end
        1: begin seg.point1_x = 16'h7FFF; seg.point1_y = 16'h7FFF; end
        2: begin seg.point2_x = 16'h7FFF; seg.point2_y = 16'h7FFF; end
        default: begin seg.point3_x = 16'h7FFF; seg.point3_y = 16'h7FFF; end
      endcase
      send_segment(seg);
    end
  endtask

  task automatic test_interval_extremes();
    // zero count reads as one interval
    write_interval_count(6'd0);
    send_segment(uniform_segment(16'h7FFF));
    send_segment({4{16'h7FFF, 16'h8000}});
    write_interval_count(6'd1);
    send_segment(uniform_segment(16'h8000));
    send_segment(random_segment());
    write_interval_count(6'd63);
    send_segment({4{16'h8000, 16'h7FFF}});
    send_segment(random_segment());
    write_interval_count(6'd2);
    send_segment(random_segment());
  endtask

  task automatic test_random_segments(input logic [CFG_W-1:0] count, input int items);
    write_interval_count(count);
    repeat (items) send_segment(random_segment());
  endtask

  task automatic test_steady_stream();
    write_interval_count(6'd8);
    steady_flow = 1'b1;
    repeat (50) send_segment(random_segment());
    wait_samples_drained();
    steady_flow = 1'b0;
  endtask

  task automatic test_random_intervals();
    repeat (30) begin
      write_interval_count(6'($urandom_range(1, 20)));
      send_segment(random_segment());
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_interval();
    test_interval_extremes();
    test_random_segments(6'd16, 140);
    test_random_segments(6'd1, 90);
    test_random_segments(6'd0, 40);
    test_random_segments(6'd5, 70);
    test_random_segments(6'd63, 8);
    test_steady_stream();
    test_random_intervals();

    wait_samples_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
